FILE: hw/rtl/hss_pkg.sv
// Shared types, codes and the half-step coil table for the stepper sequencer.
package hss_pkg;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_START_FIN  = 2'd1,
		OP_START_CONT = 2'd2,
		OP_STOP       = 2'd3
	} op_t;

	// Motion modes
	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_FINITE = 2'd1,
		MODE_CONT   = 2'd2
	} mode_t;

	// Configuration register indexes
	localparam logic REG_STEP_INTERVAL = 1'b0;
	localparam logic REG_FINITE_STEPS  = 1'b1;

	localparam int INTERVAL_W = 20;
	localparam int STEPS_W    = 16;
	localparam int PHASE_W    = 3;
	localparam int COILS_W    = 4;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd2000;
	localparam logic [STEPS_W-1:0]    STEPS_RESET    = 16'd128;

	// Half-step coil pattern, bit0 IN1 to bit3 IN4
	function automatic logic [COILS_W-1:0] half_step_coils(input logic [PHASE_W-1:0] ph);
		logic [COILS_W-1:0] pat;
		case (ph)
			3'd0:    pat = 4'h1;
			3'd1:    pat = 4'h3;
			3'd2:    pat = 4'h2;
			3'd3:    pat = 4'h6;
			3'd4:    pat = 4'h4;
			3'd5:    pat = 4'hC;
			3'd6:    pat = 4'h8;
			3'd7:    pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

FILE: hw/rtl/half_step_stepper_sequencer.sv
// Half-step unipolar stepper sequencer: input register, step logic, output register.
//
// One result item per input item, one item per clock sustained while results
// are taken without stalls: an item is captured in an input register, then
// the step logic (interval and budget counters plus the eight-entry coil
// table) updates the motion state and loads the result register, which
// drives the output. The input side keeps accepting while a
// result waits, as long as the result register is free or being taken.
// Configuration writes are always accepted and should only be issued when
// no item is in flight.
module half_step_stepper_sequencer
	import hss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] direction, [7:1] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [3:0] coils, [5:4] motion_mode, [6] step_taken,
	                                    // [7] move_done
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data
);

	// configuration registers
	logic [INTERVAL_W-1:0] step_interval_q;
	logic [STEPS_W-1:0]    finite_steps_q;

	// input stage
	logic  valid_s1;
	op_t   op_s1;
	logic  dir_s1;

	// motion state
	mode_t                 mode_q;
	logic                  reverse_q;
	logic [STEPS_W-1:0]    steps_left_q;
	logic [PHASE_W-1:0]    phase_q;
	logic [INTERVAL_W-1:0] wait_q;
	logic [COILS_W-1:0]    coils_q;

	// next state
	mode_t                 mode_d;
	logic                  reverse_d;
	logic [STEPS_W-1:0]    steps_left_d;
	logic [PHASE_W-1:0]    phase_d;
	logic [INTERVAL_W-1:0] wait_d;
	logic [COILS_W-1:0]    coils_d;
	logic                  taken_d;
	logic                  done_d;
	logic [STEPS_W-1:0]    steps_dec;

	// result register
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_q <= INTERVAL_RESET;
			finite_steps_q  <= STEPS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STEP_INTERVAL: step_interval_q <= cfg_data;
				REG_FINITE_STEPS:  finite_steps_q  <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1  <= op_t'(s_axis_tuser);
			dir_s1 <= s_axis_tdata[0];
		end
	end

	// step logic
	always_comb begin
		mode_d       = mode_q;
		reverse_d    = reverse_q;
		steps_left_d = steps_left_q;
		phase_d      = phase_q;
		wait_d       = wait_q;
		coils_d      = coils_q;
		taken_d      = 1'b0;
		done_d       = 1'b0;
		steps_dec    = (steps_left_q != '0) ? steps_left_q - 1'b1 : steps_left_q;
		case (op_s1)
			OP_START_FIN: begin
				mode_d       = MODE_FINITE;
				reverse_d    = dir_s1;
				steps_left_d = (finite_steps_q == '0) ? STEPS_W'(1) : finite_steps_q;
				wait_d       = '0;
			end
			OP_START_CONT: begin
				mode_d    = MODE_CONT;
				reverse_d = dir_s1;
				wait_d    = '0;
			end
			OP_STOP: begin
				mode_d       = MODE_IDLE;
				steps_left_d = '0;
				coils_d      = '0;
			end
			OP_TICK: begin
				if (mode_q != MODE_IDLE) begin
					if (wait_q != '0) begin
						wait_d = wait_q - 1'b1;
					end else begin
						// take a half-step and rearm the interval
						phase_d = reverse_q ? phase_q - 1'b1 : phase_q + 1'b1;
						coils_d = half_step_coils(phase_d);
						wait_d  = (step_interval_q == '0) ? '0 : step_interval_q - 1'b1;
						taken_d = 1'b1;
						if (mode_q == MODE_FINITE) begin
							steps_left_d = steps_dec;
							if (steps_dec == '0) begin
								mode_d  = MODE_IDLE;
								coils_d = '0;
								done_d  = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			reverse_q    <= 1'b0;
			steps_left_q <= '0;
			phase_q      <= '0;
			wait_q       <= '0;
			coils_q      <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			reverse_q    <= reverse_d;
			steps_left_q <= steps_left_d;
			phase_q      <= phase_d;
			wait_q       <= wait_d;
			coils_q      <= coils_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {done_d, taken_d, mode_d, coils_d};
		end
	end

	// a completed finite move leaves the motor idle and released
	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[7]) |-> (m_axis_tdata[5:4] == MODE_IDLE
			&& m_axis_tdata[3:0] == '0))
		else $error("move_done without idle and released coils");

	// idle carries no leftover step budget
	a_idle_no_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (steps_left_q == '0))
		else $error("idle with nonzero step budget");

	// a step that does not end the move drives a nonzero pattern
	a_step_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[6] && !m_axis_tdata[7]) |-> (m_axis_tdata[3:0] != '0))
		else $error("step taken with released coils");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the half-step stepper sequencer: predictor, driver and monitor.
module testbench;
	import hss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_IDLE    = 8;
	localparam int REPORT_MAX  = 10;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 110;

	// Our own copy of the half-step coil sequence
	localparam logic [3:0] HALF_PATTERN [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

	typedef enum logic [1:0] {
		CMD_ITEM,
		CMD_CFG,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct {
		cmd_kind_t   kind;
		op_t         op;
		logic        dir;
		logic        idx;
		logic [19:0] data;
	} motor_cmd_t;

	typedef struct {
		logic [3:0] coils;
		mode_t      mode;
		logic       taken;
		logic       done;
	} coil_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;     // [0] direction, [7:1] zero
	logic [1:0]  s_axis_tuser = OP_TICK; // [1:0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // [3:0] coils, [5:4] motion_mode, [6] step_taken,
	                                    // [7] move_done
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_STEP_INTERVAL;
	logic [19:0] cfg_data = '0;

	half_step_stepper_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	motor_cmd_t   motor_cmds[$];
	coil_result_t coil_results_due[$];

	// Predicted motor state and register copies
	logic [19:0] want_interval = INTERVAL_RESET;
	logic [15:0] want_budget   = STEPS_RESET;
	mode_t       mot_mode      = MODE_IDLE;
	logic        mot_reverse   = 1'b0;
	logic [15:0] mot_left      = '0;
	logic [2:0]  mot_phase     = '0;
	logic [19:0] mot_wait      = '0;
	logic [3:0]  mot_coils     = '0;

	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned steps_seen = 0;
	int unsigned moves_done = 0;
	int unsigned cfg_writes = 0;

	// Handshake flags seen at the last rising edge
	logic in_took = 1'b0;
	logic out_took = 1'b0;
	logic cfg_took = 1'b0;

	int  send_gap = 0;
	int  recv_stall = 0;
	logic send_calm = 1'b0;
	logic recv_calm = 1'b0;

	// Apply one item to the predicted state and return the result it causes
	function automatic coil_result_t advance_motor(input op_t op, input logic dir);
		coil_result_t r;
		logic [19:0] iv;
		r.taken = 1'b0;
		r.done = 1'b0;
		case (op)
			OP_START_FIN: begin
				mot_mode = MODE_FINITE;
				mot_reverse = dir;
				mot_left = (want_budget == 16'd0) ? 16'd1 : want_budget;
				mot_wait = '0;
			end
			OP_START_CONT: begin
				mot_mode = MODE_CONT;
				mot_reverse = dir;
				mot_wait = '0;
			end
			OP_STOP: begin
				mot_mode = MODE_IDLE;
				mot_left = '0;
				mot_coils = '0;
			end
			default: begin
				if (mot_mode != MODE_IDLE) begin
					if (mot_wait != 20'd0) begin
						mot_wait = mot_wait - 20'd1;
					end else begin
						iv = (want_interval == 20'd0) ? 20'd1 : want_interval;
						mot_phase = mot_reverse ? mot_phase - 3'd1 : mot_phase + 3'd1;
						mot_coils = HALF_PATTERN[mot_phase];
						mot_wait = iv - 20'd1;
						r.taken = 1'b1;
						if (mot_mode == MODE_FINITE) begin
							if (mot_left != 16'd0)
								mot_left = mot_left - 16'd1;
							if (mot_left == 16'd0) begin
								mot_mode = MODE_IDLE;
								mot_coils = '0;
								r.done = 1'b1;
							end
						end
					end
				end
			end
		endcase
		r.coils = mot_coils;
		r.mode = mot_mode;
		return r;
	endfunction

	task automatic add_item(input op_t op, input logic dir);
		motor_cmd_t c;
		c.kind = CMD_ITEM;
		c.op = op;
		c.dir = dir;
		c.idx = REG_STEP_INTERVAL;
		c.data = '0;
		motor_cmds.push_back(c);
	endtask

	task automatic add_cfg(input logic idx, input logic [19:0] data);
		motor_cmd_t c;
		c.kind = CMD_CFG;
		c.op = OP_TICK;
		c.dir = 1'b0;
		c.idx = idx;
		c.data = data;
		motor_cmds.push_back(c);
	endtask

	task automatic add_drain();
		motor_cmd_t c;
		c.kind = CMD_DRAIN;
		c.op = OP_TICK;
		c.dir = 1'b0;
		c.idx = REG_STEP_INTERVAL;
		c.data = '0;
		motor_cmds.push_back(c);
	endtask

	// Monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin
		coil_result_t want;
		cycle_count <= cycle_count + 1;
		in_took <= s_axis_tvalid && s_axis_tready;
		out_took <= m_axis_tvalid && m_axis_tready;
		cfg_took <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (m_axis_tdata[6])
					steps_seen++;
				if (m_axis_tdata[7])
					moves_done++;
				if (coil_results_due.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: result with nothing expected, tdata=%h", $realtime,
							m_axis_tdata);
				end else begin
					want = coil_results_due.pop_front();
					if (m_axis_tdata[3:0] !== want.coils || m_axis_tdata[5:4] !== want.mode ||
						m_axis_tdata[6] !== want.taken || m_axis_tdata[7] !== want.done) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display({"%0t: mismatch coils %h/%h mode %0d/%0d taken %b/%b ",
								"done %b/%b (expected/actual)"}, $realtime,
								want.coils, m_axis_tdata[3:0], want.mode, m_axis_tdata[5:4],
								want.taken, m_axis_tdata[6], want.done, m_axis_tdata[7]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				items_sent++;
				coil_results_due.push_back(advance_motor(op_t'(s_axis_tuser), s_axis_tdata[0]));
			end
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				if (cfg_index == REG_STEP_INTERVAL)
					want_interval = cfg_data;
				else
					want_budget = cfg_data[15:0];
			end
		end
	end

	// Driver: items, register writes and drain points, all changed on the falling edge
	always @(negedge clk) begin
		logic nv;
		logic ncv;
		motor_cmd_t c;
		if (arst_n) begin
			nv = s_axis_tvalid;
			ncv = cfg_valid;
			if (nv && in_took) begin
				nv = 1'b0;
				if ($urandom_range(0, 59) == 0)
					send_calm = ~send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (ncv && cfg_took)
				ncv = 1'b0;
			if (!nv && !ncv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (motor_cmds.size() > 0) begin
					c = motor_cmds[0];
					case (c.kind)
						CMD_ITEM: begin
							void'(motor_cmds.pop_front());
							s_axis_tuser <= c.op;
							s_axis_tdata <= {7'd0, c.dir};
							nv = 1'b1;
						end
						CMD_CFG: begin
							if (coil_results_due.size() == 0) begin
								void'(motor_cmds.pop_front());
								cfg_index <= c.idx;
								cfg_data <= c.data;
								ncv = 1'b1;
							end
						end
						default: begin
							if (coil_results_due.size() == 0)
								void'(motor_cmds.pop_front());
						end
					endcase
				end
			end
			s_axis_tvalid <= nv;
			cfg_valid <= ncv;

			// Receiver may stall after each taken result
			if (out_took) begin
				if ($urandom_range(0, 59) == 0)
					recv_calm = ~recv_calm;
				recv_stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Run-length guard
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [19:0] ivals [PHASES];
		logic [15:0] budgets [PHASES];
		int r;

		// Directed: reset registers, idle tick, first step, stop releases
		add_item(OP_TICK, 1'b1);
		add_item(OP_START_FIN, 1'b0);
		add_item(OP_TICK, 1'b0);
		add_item(OP_TICK, 1'b1);
		add_item(OP_STOP, 1'b1);
		add_drain();
		// Zero interval and zero budget both act as one
		add_cfg(REG_STEP_INTERVAL, 20'd0);
		add_cfg(REG_FINITE_STEPS, 20'hF0000);
		add_item(OP_START_FIN, 1'b1);
		add_item(OP_TICK, 1'b0);
		add_item(OP_TICK, 1'b0);
		add_item(OP_START_CONT, 1'b1);
		add_item(OP_TICK, 1'b0);
		add_item(OP_TICK, 1'b1);
		add_item(OP_TICK, 1'b0);
		// Restart while moving keeps the coils until the next step
		add_item(OP_START_CONT, 1'b0);
		add_item(OP_TICK, 1'b0);
		add_item(OP_START_FIN, 1'b0);
		add_item(OP_TICK, 1'b0);
		add_item(OP_STOP, 1'b0);
		add_drain();
		add_cfg(REG_STEP_INTERVAL, 20'd3);
		add_cfg(REG_FINITE_STEPS, 20'd2);
		add_item(OP_START_FIN, 1'b1);
		for (int i = 0; i < 5; i++)
			add_item(OP_TICK, 1'b0);
		add_item(OP_START_FIN, 1'b0);
		add_item(OP_TICK, 1'b1);
		add_item(OP_STOP, 1'b1);
		add_item(OP_TICK, 1'b0);

		// Register settings per random phase, extremes first
		ivals[0] = 20'hFFFFF; budgets[0] = 16'hFFFF;
		ivals[1] = 20'd1;     budgets[1] = 16'd1;
		ivals[2] = 20'd0;     budgets[2] = 16'd0;
		ivals[3] = 20'd1;     budgets[3] = 16'hFFFF;
		for (int p = 4; p < PHASES; p++) begin
			ivals[p] = 20'($urandom_range(1, 6));
			budgets[p] = 16'($urandom_range(1, 12));
		end

		for (int p = 0; p < PHASES; p++) begin
			add_drain();
			if ($urandom_range(0, 1)) begin
				add_cfg(REG_STEP_INTERVAL, ivals[p]);
				add_cfg(REG_FINITE_STEPS, {4'($urandom), budgets[p]});
			end else begin
				add_cfg(REG_FINITE_STEPS, {4'($urandom), budgets[p]});
				add_cfg(REG_STEP_INTERVAL, ivals[p]);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 72)
					add_item(OP_TICK, 1'($urandom));
				else if (r < 82)
					add_item(OP_START_FIN, 1'($urandom));
				else if (r < 92)
					add_item(OP_START_CONT, 1'($urandom));
				else
					add_item(OP_STOP, 1'($urandom));
				if (i == PHASE_ITEMS / 2)
					add_drain();
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (motor_cmds.size() > 0 || s_axis_tvalid || cfg_valid)
			@(posedge clk);
		while (coil_results_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		fail_count += coil_results_due.size();

		$display("Sent %0d items, checked %0d results, %0d register writes.",
			items_sent, results_seen, cfg_writes);
		$display("Saw %0d half-steps and %0d completed finite moves, %0d mismatches.",
			steps_seen, moves_done, mismatch_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
